@@ rtl/epbm_pkg.sv @@
// Shared constants, types and state encodings of the edge polyline breakpoint marker.
package epbm_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 8;
   localparam int LEN_BITS   = 16 + FRAC_BITS;
   localparam int THR_BITS   = 24;

   // Squared distance, radicand and root widths of the distance unit.
   localparam int D2_BITS   = 2 * COORD_BITS + 1;
   localparam int RES_BITS  = (D2_BITS + 2 * FRAC_BITS + 1) / 2;
   localparam int RAD_BITS  = 2 * RES_BITS;
   localparam int REM_BITS  = RES_BITS + 2;
   localparam int CNT_BITS  = $clog2(RES_BITS);
   localparam int ROOT_CMP_BITS = (RES_BITS > LEN_BITS) ? RES_BITS : LEN_BITS;
   localparam int DIFF_CMP_BITS = (LEN_BITS > THR_BITS) ? LEN_BITS : THR_BITS;

   localparam logic [63:0] D2_SAT = 64'h0000_0001_0000_0000;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [LEN_BITS-1:0]   len_type;
   typedef logic [THR_BITS-1:0]   thr_type;

   localparam len_type LEN_MAX   = '1;
   localparam thr_type THR_RESET = THR_BITS'(256);

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef enum logic [2:0] {
      DIST_IDLE,
      DIST_SQX,
      DIST_SQY,
      DIST_ROOT,
      DIST_DONE
   } dist_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_DECIDE,
      ST_EMIT_PRIOR,
      ST_EMIT_LAST
   } ctrl_state_type;

endpackage

@@ rtl/epbm_req_if.sv @@
// Input point channel: valid/ready handshake carrying one edge point per beat.
interface epbm_req_if;
   logic                valid;
   logic                ready;
   epbm_pkg::coord_type point_x;
   epbm_pkg::coord_type point_y;
   logic                first_of_edge;
   logic                last_of_edge;

   modport source (output valid, point_x, point_y, first_of_edge, last_of_edge,
                   input ready);
   modport sink   (input valid, point_x, point_y, first_of_edge, last_of_edge,
                   output ready);
endinterface

@@ rtl/epbm_rsp_if.sv @@
// Result channel: valid/ready handshake carrying one keep decision per beat.
interface epbm_rsp_if;
   logic                valid;
   logic                ready;
   epbm_pkg::coord_type kept_x;
   epbm_pkg::coord_type kept_y;
   logic                keep_point;
   logic                last_of_run;

   modport source (output valid, kept_x, kept_y, keep_point, last_of_run,
                   input ready);
   modport sink   (input valid, kept_x, kept_y, keep_point, last_of_run,
                   output ready);
endinterface

@@ rtl/epbm_dist.sv @@
// Distance unit: squares both offsets on one multiplier in turn, then a bit-serial integer square root.
module epbm_dist (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  epbm_pkg::point_type a_pt,
   input  epbm_pkg::point_type b_pt,
   output logic                done,
   output epbm_pkg::len_type   len
);

   epbm_pkg::dist_state_type state_ff, state_in;

   epbm_pkg::coord_type dx_ff, dx_in, dy_ff, dy_in, mul_op;
   logic [2*epbm_pkg::COORD_BITS-1:0] sq_ff, sq_in, prod;
   logic [epbm_pkg::D2_BITS-1:0]      d2_sum;
   logic [63:0]                       d2_wide;
   logic [epbm_pkg::RAD_BITS-1:0]     rad_ff, rad_in;
   logic [epbm_pkg::REM_BITS-1:0]     rem_ff, rem_in, rem_sh, trial;
   logic [epbm_pkg::RES_BITS-1:0]     root_ff, root_in;
   logic [epbm_pkg::CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [epbm_pkg::ROOT_CMP_BITS-1:0] root_wide;
   logic                              sat_ff, sat_in, ge;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         epbm_pkg::DIST_IDLE: begin
            if (start) state_in = epbm_pkg::DIST_SQX;
         end
         epbm_pkg::DIST_SQX:  state_in = epbm_pkg::DIST_SQY;
         epbm_pkg::DIST_SQY:  state_in = epbm_pkg::DIST_ROOT;
         epbm_pkg::DIST_ROOT: begin
            if (cnt_ff == '0) state_in = epbm_pkg::DIST_DONE;
         end
         epbm_pkg::DIST_DONE: state_in = epbm_pkg::DIST_IDLE;
         default:             state_in = epbm_pkg::DIST_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      done   = (state_ff == epbm_pkg::DIST_DONE);
      mul_op = (state_ff == epbm_pkg::DIST_SQX) ? dx_ff : dy_ff;
   end

   // Datapath: one multiplier shared by both squares, one root bit per cycle.
   always_comb begin
      prod    = mul_op * mul_op;
      d2_sum  = epbm_pkg::D2_BITS'(sq_ff) + epbm_pkg::D2_BITS'(prod);
      d2_wide = 64'(d2_sum);
      rem_sh  = {rem_ff[epbm_pkg::RES_BITS-1:0], rad_ff[epbm_pkg::RAD_BITS-1 -: 2]};
      trial   = {root_ff, 2'b01};
      ge      = (rem_sh >= trial);

      dx_in   = dx_ff;
      dy_in   = dy_ff;
      sq_in   = sq_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      sat_in  = sat_ff;

      unique case (state_ff)
         epbm_pkg::DIST_IDLE: begin
            if (start) begin
               dx_in = (a_pt.x > b_pt.x) ? a_pt.x - b_pt.x : b_pt.x - a_pt.x;
               dy_in = (a_pt.y > b_pt.y) ? a_pt.y - b_pt.y : b_pt.y - a_pt.y;
            end
         end
         epbm_pkg::DIST_SQX: begin
            sq_in = prod;
         end
         epbm_pkg::DIST_SQY: begin
            rad_in  = epbm_pkg::RAD_BITS'(d2_sum) << (2 * epbm_pkg::FRAC_BITS);
            sat_in  = (d2_wide >= epbm_pkg::D2_SAT);
            rem_in  = '0;
            root_in = '0;
            cnt_in  = epbm_pkg::CNT_BITS'(epbm_pkg::RES_BITS - 1);
         end
         epbm_pkg::DIST_ROOT: begin
            rem_in  = ge ? rem_sh - trial : rem_sh;
            root_in = {root_ff[epbm_pkg::RES_BITS-2:0], ge};
            rad_in  = rad_ff << 2;
            cnt_in  = cnt_ff - 1'b1;
         end
         epbm_pkg::DIST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign root_wide = epbm_pkg::ROOT_CMP_BITS'(root_ff);
   assign len = (sat_ff || root_wide > epbm_pkg::ROOT_CMP_BITS'(epbm_pkg::LEN_MAX)) ?
                epbm_pkg::LEN_MAX : epbm_pkg::LEN_BITS'(root_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= epbm_pkg::DIST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sq_ff   <= sq_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      sat_ff  <= sat_in;
   end

endmodule

@@ rtl/edge_polyline_breakpoint_marker.sv @@
// Top level of the edge polyline breakpoint marker: control, state and result beats.
//
// Edge points arrive one per beat on req_chan and each point's keep flag leaves on
// rsp_chan once the following point has settled it, in point order, with the last
// point of an edge always kept. A point that opens an edge runs no distance units.
// Every other point runs two distance units side by side (step from the previous
// point, chord from the anchor). Each unit squares its offsets in turn, extracts a
// 21-bit square root one bit per cycle and then flags its result. The keep decision
// follows in its own state, so such a point keeps the block busy after it is taken
// until its first result beat is offered. Each result beat is held until taken,
// and a point yields at most two beats. The block takes no new point until the
// results of the current one have all been taken. The threshold register is written
// through csr_wr_en/csr_wr_data and resets to 1.0 pixel.
module edge_polyline_breakpoint_marker (
   input  logic                  clock,
   input  logic                  reset,
   epbm_req_if.sink              req_chan,
   epbm_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  epbm_pkg::thr_type     csr_wr_data
);

   epbm_pkg::ctrl_state_type state_ff, state_in;

   epbm_pkg::thr_type   thr_ff;
   epbm_pkg::coord_type anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   epbm_pkg::coord_type prior_x_ff, prior_x_in, prior_y_ff, prior_y_in;
   epbm_pkg::coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   epbm_pkg::coord_type emit_x_ff, emit_x_in, emit_y_ff, emit_y_in;
   epbm_pkg::len_type   arc_ff, arc_in, sum_ff, sum_in;
   epbm_pkg::len_type   step_len, chord_len, diff;
   logic [epbm_pkg::LEN_BITS:0] arc_add;
   logic                prior_keep_ff, prior_keep_in;
   logic                inside_ff, inside_in;
   logic                cur_last_ff, cur_last_in;
   logic                has_prior_ff, has_prior_in;
   logic                emit_keep_ff, emit_keep_in;
   logic                req_beat, rsp_beat, new_edge, brk, start_dist;
   logic                step_done, chord_done;
   epbm_pkg::point_type prior_pt, anchor_pt, cur_pt;

   assign req_beat = req_chan.valid && req_chan.ready;
   assign rsp_beat = rsp_chan.valid && rsp_chan.ready;

   // A point opens a new edge when it says so, or when no edge is open.
   assign new_edge = req_chan.first_of_edge || !inside_ff;

   assign prior_pt  = '{x: prior_x_ff,  y: prior_y_ff};
   assign anchor_pt = '{x: anchor_x_ff, y: anchor_y_ff};
   assign cur_pt    = '{x: req_chan.point_x, y: req_chan.point_y};

   // Step length from the previous point and chord from the anchor run in lockstep.
   epbm_dist u_step (
      .clock (clock),
      .reset (reset),
      .start (start_dist),
      .a_pt  (prior_pt),
      .b_pt  (cur_pt),
      .done  (step_done),
      .len   (step_len)
   );

   epbm_dist u_chord (
      .clock (clock),
      .reset (reset),
      .start (start_dist),
      .a_pt  (anchor_pt),
      .b_pt  (cur_pt),
      .done  (chord_done),
      .len   (chord_len)
   );

   // The arc saturates at the largest representable length.
   assign arc_add = {1'b0, arc_ff} + {1'b0, step_len};

   // The previous point breaks the polyline when |arc - chord| exceeds the threshold.
   assign diff = (sum_ff > chord_len) ? sum_ff - chord_len : chord_len - sum_ff;
   assign brk  = epbm_pkg::DIFF_CMP_BITS'(diff) > epbm_pkg::DIFF_CMP_BITS'(thr_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         epbm_pkg::ST_IDLE: begin
            if (req_beat) begin
               priority if (!new_edge)          state_in = epbm_pkg::ST_DIST;
               else if (inside_ff)              state_in = epbm_pkg::ST_EMIT_PRIOR;
               else if (req_chan.last_of_edge)  state_in = epbm_pkg::ST_EMIT_LAST;
               else                             state_in = epbm_pkg::ST_IDLE;
            end
         end
         epbm_pkg::ST_DIST: begin
            if (step_done) state_in = epbm_pkg::ST_DECIDE;
         end
         epbm_pkg::ST_DECIDE: state_in = epbm_pkg::ST_EMIT_PRIOR;
         epbm_pkg::ST_EMIT_PRIOR: begin
            if (rsp_chan.ready) begin
               state_in = cur_last_ff ? epbm_pkg::ST_EMIT_LAST : epbm_pkg::ST_IDLE;
            end
         end
         epbm_pkg::ST_EMIT_LAST: begin
            if (rsp_chan.ready) state_in = epbm_pkg::ST_IDLE;
         end
         default: state_in = epbm_pkg::ST_IDLE;
      endcase
   end

   // Handshake and result payload. The pending previous point goes first; the
   // closing point of an edge follows and is always kept.
   always_comb begin
      req_chan.ready      = (state_ff == epbm_pkg::ST_IDLE);
      start_dist          = (state_ff == epbm_pkg::ST_IDLE) && req_beat && !new_edge;
      rsp_chan.valid      = (state_ff == epbm_pkg::ST_EMIT_PRIOR) ||
                            (state_ff == epbm_pkg::ST_EMIT_LAST);
      if (state_ff == epbm_pkg::ST_EMIT_LAST) begin
         rsp_chan.kept_x      = cur_x_ff;
         rsp_chan.kept_y      = cur_y_ff;
         rsp_chan.keep_point  = 1'b1;
         rsp_chan.last_of_run = 1'b1;
      end else begin
         rsp_chan.kept_x      = emit_x_ff;
         rsp_chan.kept_y      = emit_y_ff;
         rsp_chan.keep_point  = emit_keep_ff;
         rsp_chan.last_of_run = !cur_last_ff;
      end
   end

   // Tracking state of the open edge.
   always_comb begin
      anchor_x_in   = anchor_x_ff;
      anchor_y_in   = anchor_y_ff;
      prior_x_in    = prior_x_ff;
      prior_y_in    = prior_y_ff;
      prior_keep_in = prior_keep_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      cur_last_in   = cur_last_ff;
      inside_in     = inside_ff;
      has_prior_in  = has_prior_ff;
      emit_x_in     = emit_x_ff;
      emit_y_in     = emit_y_ff;
      emit_keep_in  = emit_keep_ff;
      arc_in        = arc_ff;
      sum_in        = sum_ff;

      unique case (state_ff)
         epbm_pkg::ST_IDLE: begin
            if (req_beat) begin
               cur_x_in    = req_chan.point_x;
               cur_y_in    = req_chan.point_y;
               cur_last_in = req_chan.last_of_edge;
               inside_in   = !req_chan.last_of_edge;
               if (new_edge) begin
                  // An edge left open ends at its previous point, which is kept.
                  has_prior_in  = inside_ff;
                  emit_x_in     = prior_x_ff;
                  emit_y_in     = prior_y_ff;
                  emit_keep_in  = 1'b1;
                  anchor_x_in   = req_chan.point_x;
                  anchor_y_in   = req_chan.point_y;
                  prior_x_in    = req_chan.point_x;
                  prior_y_in    = req_chan.point_y;
                  prior_keep_in = 1'b1;
                  arc_in        = '0;
               end else begin
                  has_prior_in  = 1'b1;
               end
            end
         end
         epbm_pkg::ST_DIST: begin
            if (step_done) begin
               sum_in = arc_add[epbm_pkg::LEN_BITS] ? epbm_pkg::LEN_MAX :
                        arc_add[epbm_pkg::LEN_BITS-1:0];
            end
         end
         epbm_pkg::ST_DECIDE: begin
            emit_x_in    = prior_x_ff;
            emit_y_in    = prior_y_ff;
            emit_keep_in = brk || prior_keep_ff;
            if (brk) begin
               // The previous point becomes the anchor and the arc restarts at the
               // last step, which then equals the chord, so the point is settled.
               anchor_x_in = prior_x_ff;
               anchor_y_in = prior_y_ff;
               arc_in      = step_len;
            end else begin
               arc_in      = sum_ff;
            end
            prior_x_in    = cur_x_ff;
            prior_y_in    = cur_y_ff;
            prior_keep_in = 1'b0;
         end
         epbm_pkg::ST_EMIT_PRIOR: begin
         end
         epbm_pkg::ST_EMIT_LAST: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= epbm_pkg::ST_IDLE;
         thr_ff       <= epbm_pkg::THR_RESET;
         inside_ff    <= 1'b0;
         has_prior_ff <= 1'b0;
         cur_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inside_ff    <= inside_in;
         has_prior_ff <= has_prior_in;
         cur_last_ff  <= cur_last_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
      anchor_x_ff   <= anchor_x_in;
      anchor_y_ff   <= anchor_y_in;
      prior_x_ff    <= prior_x_in;
      prior_y_ff    <= prior_y_in;
      prior_keep_ff <= prior_keep_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      emit_x_ff     <= emit_x_in;
      emit_y_ff     <= emit_y_in;
      emit_keep_ff  <= emit_keep_in;
      arc_ff        <= arc_in;
      sum_ff        <= sum_in;
   end

   // The two distance units are started together and must finish together.
   a_units_lockstep: assert property (@(posedge clock) disable iff (reset)
      step_done == chord_done)
      else $error("distance units out of step");

   // After a break the arc length restarts at the last step length.
   a_break_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == epbm_pkg::ST_DECIDE && brk) |=> (arc_ff == $past(step_len)))
      else $error("arc length not restarted after a break");

   // Once the final beat of a point is taken the block is free for the next point.
   a_run_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_chan.last_of_run) |=> (!rsp_chan.valid && req_chan.ready))
      else $error("result run did not close");

   // A prior result beat exists only where a pending point was recorded.
   a_prior_recorded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == epbm_pkg::ST_EMIT_PRIOR) |-> has_prior_ff)
      else $error("prior result without a pending point");

endmodule
